// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
// Every check is clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BBTA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define BBTA_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ----- hdl/bbta_pkg.sv -----
// ----------------------------------------------------------------------------
// bbta_pkg
// Types and codes shared by the controller and datapath of the buddy
// bitmap tree allocator.
// ----------------------------------------------------------------------------
package bbta_pkg;

	// Result status codes.
	localparam logic [2:0] ST_ALLOC     = 3'd0;
	localparam logic [2:0] ST_TOO_LARGE = 3'd1;
	localparam logic [2:0] ST_NO_BLOCK  = 3'd2;
	localparam logic [2:0] ST_FREED     = 3'd3;
	localparam logic [2:0] ST_FREED_CLR = 3'd4;
	localparam logic [2:0] ST_BAD_INDEX = 3'd5;

	// Request kinds.
	localparam logic KIND_ALLOC = 1'b0;

	// Configuration register indexes.
	localparam logic CFG_LEVELS = 1'b0;

	// Header bytes added to every allocation.
	localparam int unsigned HEADER_BYTES = 4;

	typedef logic [4:0] op_t;

	// Datapath operations.
	localparam op_t OP_NOP       = 5'd0;
	localparam op_t OP_CLR       = 5'd1;
	localparam op_t OP_START     = 5'd2;
	localparam op_t OP_LVL_STEP  = 5'd3;
	localparam op_t OP_SCAN_INIT = 5'd4;
	localparam op_t OP_ANC_RD    = 5'd5;
	localparam op_t OP_ANC_NEXT  = 5'd6;
	localparam op_t OP_DESC_INIT = 5'd7;
	localparam op_t OP_DESC_RD   = 5'd8;
	localparam op_t OP_DESC_NEXT = 5'd9;
	localparam op_t OP_N_NEXT    = 5'd10;
	localparam op_t OP_MARK      = 5'd11;
	localparam op_t OP_BUD_RD    = 5'd12;
	localparam op_t OP_BUD_SET   = 5'd13;
	localparam op_t OP_FREE_RD   = 5'd14;
	localparam op_t OP_FREE_WR   = 5'd15;
	localparam op_t OP_OFFSET    = 5'd16;
	localparam op_t OP_RESULT    = 5'd17;

	typedef struct packed {
		op_t        op;
		logic [2:0] code;
	} cmd_t;

	typedef struct packed {
		logic rd_bit;
		logic too_large;
		logic bad_index;
		logic lvl_cont;
		logic p_one;
		logic p_le_one;
		logic p_zero;
		logic desc_done;
		logic n_last;
		logic clr_last;
		logic out_busy;
	} dp_stat_t;

endpackage

// ----- hdl/bbta_ram.sv -----
// ----------------------------------------------------------------------------
// bbta_ram
// Generic single-port RAM with a registered read, read before write.
// ----------------------------------------------------------------------------
module bbta_ram #(
	parameter int W = 1,
	parameter int D = 2048
) (
	input  logic                 clk,
	input  logic [$clog2(D)-1:0] addr,
	input  logic                 we,
	input  logic [W-1:0]         wdata,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	// One access per cycle; read data appears on the next cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ----- hdl/bbta_dp.sv -----
// ----------------------------------------------------------------------------
// bbta_dp
// Datapath: configuration, request registers, tree walk pointers, the tree
// bitmap RAM, the offset multiplier and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbta_dp #(
	parameter int MAX_LEVEL_COUNT = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bbta_pkg::cmd_t      cmd,
	output bbta_pkg::dp_stat_t  st,
	input  logic                cfg_valid,
	input  logic                cfg_index,
	input  logic [16:0]         cfg_data,
	input  logic [25:0]         request_bytes,
	input  logic [10:0]         free_node,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic [10:0]         node_index,
	output logic [3:0]          level,
	output logic [24:0]         byte_offset
);

	localparam int NW = MAX_LEVEL_COUNT + 1;
	localparam int PW = NW + 17;
	localparam logic [3:0] LMAX = 4'(MAX_LEVEL_COUNT - 1);

	logic [3:0]    levels_q;
	logic [16:0]   bucket_q;
	logic [3:0]    l_q;
	logic [3:0]    lvl_q;
	logic [26:0]   need_q;
	logic [31:0]   total_q;
	logic [31:0]   half_q;
	logic          bad_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] p_q;
	logic [4:0]    d_q;
	logic [NW-1:0] k_q;
	logic [NW-1:0] clr_q;
	logic [PW-1:0] prod_q;
	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [10:0]   node_q;
	logic [3:0]    level_q;
	logic [24:0]   offset_q;
	logic [24:0]   byte_offset_q;

	logic [3:0]    l_eff;
	logic [16:0]   free_ext;
	logic [16:0]   node_lim;
	logic [NW-1:0] first_node;
	logic [NW-1:0] ram_addr;
	logic          ram_we;
	logic          ram_wd;
	logic          ram_rd;
	logic [NW-1:0] row_mask;
	logic [NW-1:0] idx;
	logic [PW+15:0] off_wide;
	logic [10:0]   node_out;

	assign l_eff      = (levels_q > LMAX) ? LMAX : levels_q;
	assign free_ext   = 17'(free_node);
	assign node_lim   = 17'(1) << (5'(l_eff) + 5'd1);
	assign first_node = NW'(1) << lvl_q;
	assign row_mask   = (NW'(1) << d_q) - NW'(1);
	assign idx        = n_q - first_node;
	assign off_wide   = (PW+16)'(prod_q) << (l_q - lvl_q);
	assign node_out   = (NW > 11) ? 11'(n_q) : 11'(n_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= 4'd9;
			bucket_q <= 17'd16;
		end else if (cfg_valid) begin
			if (cfg_index == bbta_pkg::CFG_LEVELS) begin
				levels_q <= cfg_data[3:0];
			end else begin
				bucket_q <= cfg_data;
			end
		end
	end

	// RAM port selection for each operation.
	always_comb begin
		ram_addr = p_q;
		ram_we   = 1'b0;
		ram_wd   = 1'b0;
		case (cmd.op)
			bbta_pkg::OP_CLR: begin
				ram_addr = clr_q;
				ram_we   = 1'b1;
			end
			bbta_pkg::OP_DESC_RD: ram_addr = (n_q << d_q) + k_q;
			bbta_pkg::OP_MARK: begin
				ram_addr = n_q;
				ram_we   = 1'b1;
				ram_wd   = 1'b1;
			end
			bbta_pkg::OP_BUD_RD: ram_addr = p_q ^ NW'(1);
			bbta_pkg::OP_BUD_SET: begin
				ram_addr = p_q >> 1;
				ram_we   = 1'b1;
				ram_wd   = 1'b1;
			end
			bbta_pkg::OP_FREE_RD: ram_addr = n_q;
			bbta_pkg::OP_FREE_WR: ram_we = 1'b1;
			default: ram_addr = p_q;
		endcase
	end

	bbta_ram #(.W(1), .D(1 << NW)) u_tree (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (ram_wd),
		.rdata (ram_rd)
	);

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.op == bbta_pkg::OP_CLR) begin
			clr_q <= clr_q + NW'(1);
		end
	end

	// Request and walk registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			bbta_pkg::OP_START: begin
				l_q     <= l_eff;
				lvl_q   <= 4'd0;
				need_q  <= 27'(request_bytes) + 27'(bbta_pkg::HEADER_BYTES);
				total_q <= 32'(bucket_q) << l_eff;
				half_q  <= (32'(bucket_q) << l_eff) >> 1;
				bad_q   <= (free_ext == 17'd0) || (free_ext >= node_lim);
				n_q     <= free_ext[NW-1:0];
			end
			bbta_pkg::OP_LVL_STEP: begin
				lvl_q  <= lvl_q + 4'd1;
				half_q <= half_q >> 1;
			end
			bbta_pkg::OP_SCAN_INIT: begin
				n_q <= first_node;
				p_q <= first_node;
			end
			bbta_pkg::OP_ANC_NEXT: p_q <= p_q >> 1;
			bbta_pkg::OP_DESC_INIT: begin
				d_q <= 5'd1;
				k_q <= '0;
			end
			bbta_pkg::OP_DESC_NEXT: begin
				if (k_q == row_mask) begin
					d_q <= d_q + 5'd1;
					k_q <= '0;
				end else begin
					k_q <= k_q + NW'(1);
				end
			end
			bbta_pkg::OP_N_NEXT: begin
				n_q <= n_q + NW'(1);
				p_q <= n_q + NW'(1);
			end
			bbta_pkg::OP_MARK: begin
				p_q    <= n_q;
				prod_q <= PW'(idx) * PW'(bucket_q);
			end
			bbta_pkg::OP_BUD_SET: p_q <= p_q >> 1;
			bbta_pkg::OP_FREE_RD: p_q <= n_q;
			bbta_pkg::OP_FREE_WR: p_q <= p_q >> 1;
			bbta_pkg::OP_OFFSET: offset_q <= off_wide[24:0];
			default: ;
		endcase
	end

	// Output register; the next request may already be at work meanwhile.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == bbta_pkg::OP_RESULT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result fields; only an allocation carries a level and an offset.
	always_ff @(posedge clk) begin
		if (cmd.op == bbta_pkg::OP_RESULT) begin
			status_q <= cmd.code;
			if (cmd.code == bbta_pkg::ST_ALLOC) begin
				node_q        <= node_out;
				level_q       <= lvl_q;
				byte_offset_q <= offset_q;
			end else if (cmd.code == bbta_pkg::ST_FREED ||
					cmd.code == bbta_pkg::ST_FREED_CLR) begin
				node_q        <= node_out;
				level_q       <= 4'd0;
				byte_offset_q <= 25'd0;
			end else begin
				node_q        <= 11'd0;
				level_q       <= 4'd0;
				byte_offset_q <= 25'd0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign node_index  = node_q;
	assign level       = level_q;
	assign byte_offset = byte_offset_q;

	// Status towards the controller.
	always_comb begin
		st.rd_bit    = ram_rd;
		st.too_large = 32'(need_q) > total_q;
		st.bad_index = bad_q;
		st.lvl_cont  = (32'(need_q) <= half_q) && (lvl_q < l_q);
		st.p_one     = p_q == NW'(1);
		st.p_le_one  = p_q <= NW'(1);
		st.p_zero    = p_q == '0;
		st.desc_done = (5'(lvl_q) + d_q) > 5'(l_q);
		st.n_last    = n_q == ((NW'(1) << (5'(lvl_q) + 5'd1)) - NW'(1));
		st.clr_last  = clr_q == '1;
		st.out_busy  = out_valid_q;
	end

	`BBTA_ASSERT(a_result_holds, out_valid_q && !out_ready && cmd.op != bbta_pkg::OP_RESULT |=> out_valid_q && $stable(status_q), "pending result changed before transfer")
	`BBTA_NEVER(a_write_in_range, ram_we && cmd.op == bbta_pkg::OP_BUD_SET && p_q <= NW'(1), "full mark propagated above the root")

endmodule

// ----- hdl/bbta_ctrl.sv -----
// ----------------------------------------------------------------------------
// bbta_ctrl
// Controller: sequences the clearing pass, the level search, the node scan,
// the full-mark propagation and the free walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbta_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  bbta_pkg::dp_stat_t st,
	output bbta_pkg::cmd_t     cmd
);

	localparam logic [4:0] S_CLEAR     = 5'd0;
	localparam logic [4:0] S_IDLE      = 5'd1;
	localparam logic [4:0] S_DECIDE    = 5'd2;
	localparam logic [4:0] S_LVL       = 5'd3;
	localparam logic [4:0] S_CAND      = 5'd4;
	localparam logic [4:0] S_ANC_CHK   = 5'd5;
	localparam logic [4:0] S_DESC      = 5'd6;
	localparam logic [4:0] S_DESC_CHK  = 5'd7;
	localparam logic [4:0] S_REJ       = 5'd8;
	localparam logic [4:0] S_MARK      = 5'd9;
	localparam logic [4:0] S_BUD       = 5'd10;
	localparam logic [4:0] S_BUD_CHK   = 5'd11;
	localparam logic [4:0] S_OFF       = 5'd12;
	localparam logic [4:0] S_FREE_CHK  = 5'd13;
	localparam logic [4:0] S_FREE      = 5'd14;
	localparam logic [4:0] S_RES       = 5'd15;

	logic [4:0] state_q, state_d;
	logic       kind_q;
	logic [2:0] code_q, code_d;

	assign in_ready = state_q == S_IDLE;

	// Next state and datapath command.
	always_comb begin
		state_d  = state_q;
		code_d   = code_q;
		cmd.op   = bbta_pkg::OP_NOP;
		cmd.code = code_q;
		case (state_q)
			S_CLEAR: begin
				cmd.op = bbta_pkg::OP_CLR;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = bbta_pkg::OP_START;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (kind_q == bbta_pkg::KIND_ALLOC) begin
					if (st.too_large) begin
						code_d  = bbta_pkg::ST_TOO_LARGE;
						state_d = S_RES;
					end else begin
						state_d = S_LVL;
					end
				end else if (st.bad_index) begin
					code_d  = bbta_pkg::ST_BAD_INDEX;
					state_d = S_RES;
				end else begin
					cmd.op  = bbta_pkg::OP_FREE_RD;
					state_d = S_FREE_CHK;
				end
			end
			S_LVL: begin
				if (st.lvl_cont) begin
					cmd.op = bbta_pkg::OP_LVL_STEP;
				end else begin
					cmd.op  = bbta_pkg::OP_SCAN_INIT;
					state_d = S_CAND;
				end
			end
			S_CAND: begin
				cmd.op  = bbta_pkg::OP_ANC_RD;
				state_d = S_ANC_CHK;
			end
			S_ANC_CHK: begin
				if (st.rd_bit) begin
					state_d = S_REJ;
				end else if (st.p_one) begin
					cmd.op  = bbta_pkg::OP_DESC_INIT;
					state_d = S_DESC;
				end else begin
					cmd.op  = bbta_pkg::OP_ANC_NEXT;
					state_d = S_CAND;
				end
			end
			S_DESC: begin
				if (st.desc_done) begin
					state_d = S_MARK;
				end else begin
					cmd.op  = bbta_pkg::OP_DESC_RD;
					state_d = S_DESC_CHK;
				end
			end
			S_DESC_CHK: begin
				if (st.rd_bit) begin
					state_d = S_REJ;
				end else begin
					cmd.op  = bbta_pkg::OP_DESC_NEXT;
					state_d = S_DESC;
				end
			end
			S_REJ: begin
				if (st.n_last) begin
					code_d  = bbta_pkg::ST_NO_BLOCK;
					state_d = S_RES;
				end else begin
					cmd.op  = bbta_pkg::OP_N_NEXT;
					state_d = S_CAND;
				end
			end
			S_MARK: begin
				cmd.op  = bbta_pkg::OP_MARK;
				state_d = S_BUD;
			end
			S_BUD: begin
				if (st.p_le_one) begin
					state_d = S_OFF;
				end else begin
					cmd.op  = bbta_pkg::OP_BUD_RD;
					state_d = S_BUD_CHK;
				end
			end
			S_BUD_CHK: begin
				if (st.rd_bit) begin
					cmd.op  = bbta_pkg::OP_BUD_SET;
					state_d = S_BUD;
				end else begin
					state_d = S_OFF;
				end
			end
			S_OFF: begin
				cmd.op  = bbta_pkg::OP_OFFSET;
				code_d  = bbta_pkg::ST_ALLOC;
				state_d = S_RES;
			end
			S_FREE_CHK: begin
				code_d  = st.rd_bit ? bbta_pkg::ST_FREED : bbta_pkg::ST_FREED_CLR;
				cmd.op  = bbta_pkg::OP_FREE_WR;
				state_d = S_FREE;
			end
			S_FREE: begin
				if (st.p_zero) begin
					state_d = S_RES;
				end else begin
					cmd.op = bbta_pkg::OP_FREE_WR;
				end
			end
			S_RES: begin
				if (!st.out_busy) begin
					cmd.op  = bbta_pkg::OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			kind_q  <= 1'b0;
			code_q  <= bbta_pkg::ST_ALLOC;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			if (in_valid && in_ready) kind_q <= kind;
		end
	end

	`BBTA_ASSERT(a_accept_decides, in_valid && in_ready |=> state_q == S_DECIDE, "accepted request did not start")
	`BBTA_NEVER(a_no_overwrite, cmd.op == bbta_pkg::OP_RESULT && st.out_busy, "result issued over a pending one")
	`BBTA_NEVER(a_clear_blocks, state_q == S_CLEAR && in_ready, "request taken during clearing pass")

endmodule

// ----- hdl/buddy_bitmap_tree_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// buddy_bitmap_tree_allocator_unit
// Buddy allocator over a heap-numbered bitmap tree of block marks.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on in_valid/in_ready with kind, request_bytes and
// free_node; one result per request leaves on out_valid/out_ready with
// status, node_index, level and byte_offset. The configuration channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready and should be
// written only while the unit is idle.
// After reset the tree RAM clears one node per cycle, all 2^(MAX_LEVEL_COUNT+1)
// nodes (2048 by default), with in_ready low throughout.
// A request is handled one at a time, and every node test is a registered
// read of the single-port tree RAM. A free reads the node, then clears it and
// its ancestors up to the root; an allocate runs the level search, then for
// each candidate node scanned reads its ancestors and descendants, then reads
// each buddy in the full-mark walk.
// A finished result waits in the output register while the next request is
// taken; if the receiver stalls, that request stops just before delivery.
// ----------------------------------------------------------------------------
module buddy_bitmap_tree_allocator_unit #(
	parameter int MAX_LEVEL_COUNT = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [25:0] request_bytes,
	input  logic [10:0] free_node,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [10:0] node_index,
	output logic [3:0]  level,
	output logic [24:0] byte_offset,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data
);

	bbta_pkg::cmd_t     cmd;
	bbta_pkg::dp_stat_t st;

	assign cfg_ready = 1'b1;

	// Sequencer.
	bbta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.st       (st),
		.cmd      (cmd)
	);

	// Tree storage and arithmetic.
	bbta_dp #(.MAX_LEVEL_COUNT(MAX_LEVEL_COUNT)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.request_bytes (request_bytes),
		.free_node     (free_node),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.node_index    (node_index),
		.level         (level),
		.byte_offset   (byte_offset)
	);

endmodule
